@@ hw/rtl/mbsu_pkg.sv @@
// shared types, constants and the data length table for the midi byte stream unpacker
// no dependencies; mbsu_decode and the top level take their names from here
package mbsu_pkg;

    localparam int LIMIT_W = 6;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

    // stream byte codes
    localparam logic [7:0] STATUS_SYSEX = 8'hF0;
    localparam logic [7:0] STATUS_EOX   = 8'hF7;
    localparam logic [7:0] RT_MASK      = 8'hF8;
    localparam logic [3:0] SYS_NIBBLE   = 4'hF;

    // system common codes that carry data bytes
    localparam logic [3:0] SC_TIME_CODE  = 4'h1;
    localparam logic [3:0] SC_SONG_POS   = 4'h2;
    localparam logic [3:0] SC_SONG_SEL   = 4'h3;

    localparam logic KIND_SHORT = 1'b0;
    localparam logic KIND_SYSEX = 1'b1;

    // data bytes per channel voice status, indexed by status bits 6..4
    localparam logic [7:0][1:0] VOICE_LEN =
        {2'd0, 2'd2, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2};

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_SHORT = 3'b010,
        MODE_SYSEX = 3'b100
    } t_mode;

    typedef struct packed {
        logic [7:0]  midi_byte;
        logic [63:0] arrival_time;
        logic [31:0] channel_group;
        logic        buffer_end;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [23:0] short_bytes;
        logic [1:0]  short_len;
        logic [7:0]  sysex_byte;
        logic        chunk_end;
        logic        chunk_continued;
        logic [63:0] event_time;
        logic [31:0] event_group;
        logic        last;
    } t_out_item;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  running_status;
        logic [23:0] short_buffer;
        logic [1:0]  short_fill;
        logic [1:0]  bytes_left;
        logic [63:0] start_time;
    } t_parse_state;

    localparam t_parse_state PARSE_RESET = '{
        mode:           MODE_IDLE,
        running_status: 8'h00,
        short_buffer:   24'h000000,
        short_fill:     2'd0,
        bytes_left:     2'd0,
        start_time:     64'h0
    };

    // work left to do for one accepted word, in emission order
    typedef struct packed {
        logic       wr_en;
        logic [7:0] wr_data;
        logic       rt_emit;
        logic       f1_en;
        logic       f1_cont;
        logic       f0_late;
        logic       short_emit;
        logic       f2_en;
    } t_plan;

    function automatic logic [1:0] data_count(input logic [7:0] st);
        logic [1:0] n;
        if (st[7:4] != SYS_NIBBLE) begin
            n = VOICE_LEN[st[6:4]];
        end else begin
            unique case (st[3:0])
                SC_TIME_CODE: n = 2'd1;
                SC_SONG_POS:  n = 2'd2;
                SC_SONG_SEL:  n = 2'd1;
                default:      n = 2'd0;
            endcase
        end
        return n;
    endfunction

endpackage

@@ hw/rtl/mbsu_ram.sv @@
// generic single write port, single read port ram with registered read data
// no dependencies
module mbsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/mbsu_decode.sv @@
// parser step: next parse state, chunk memory write and the list of results for one word
// depends on mbsu_pkg
module mbsu_decode #(
    parameter int CHUNK_DEPTH = 32,
    localparam int FW = $clog2(CHUNK_DEPTH + 1),
    localparam int AW = $clog2(CHUNK_DEPTH)
) (
    input  logic [7:0]                    i_byte,
    input  logic [63:0]                   i_time,
    input  logic                          i_end,
    input  logic [mbsu_pkg::LIMIT_W-1:0]  i_limit,
    input  mbsu_pkg::t_parse_state        i_state,
    input  logic [FW-1:0]                 i_fill,
    output mbsu_pkg::t_parse_state        o_state,
    output logic [FW-1:0]                 o_fill,
    output mbsu_pkg::t_plan               o_plan,
    output logic [AW-1:0]                 o_wr_addr,
    output logic [FW-1:0]                 o_f1_cnt,
    output logic [FW-1:0]                 o_f2_cnt
);

    localparam int LW    = mbsu_pkg::LIMIT_W;
    localparam int CMP_W = (FW > LW) ? FW + 1 : LW + 1;

    logic          is_rt;
    logic          in_sysex;
    logic          has_room;
    logic          pass;
    logic          keep;
    logic [FW-1:0] fill_put;
    logic [LW-1:0] lim_eff;

    // zero limit acts as one, large limits saturate at the memory depth
    always_comb begin
        if (i_limit == '0) begin
            lim_eff = LW'(1);
        end else if (i_limit > LW'(CHUNK_DEPTH)) begin
            lim_eff = LW'(CHUNK_DEPTH);
        end else begin
            lim_eff = i_limit;
        end
    end

    assign is_rt    = (i_byte & mbsu_pkg::RT_MASK) == mbsu_pkg::RT_MASK;
    assign in_sysex = i_state.mode == mbsu_pkg::MODE_SYSEX;
    assign has_room = i_fill < FW'(CHUNK_DEPTH);
    assign fill_put = has_room ? i_fill + FW'(1) : i_fill;

    always_comb begin
        o_state   = i_state;
        o_fill    = i_fill;
        o_plan    = '0;
        o_wr_addr = i_fill[AW-1:0];
        o_f1_cnt  = i_fill;
        o_f2_cnt  = '0;
        pass      = 1'b1;
        keep      = 1'b1;

        // realtime bytes and bytes inside sysex
        if (is_rt) begin
            o_plan.rt_emit = 1'b1;
            pass           = 1'b0;
            if (in_sysex && i_fill != '0) begin
                o_plan.f1_en   = 1'b1;
                o_plan.f1_cont = 1'b1;
                o_f1_cnt       = i_fill;
                o_fill         = '0;
            end
        end else if (in_sysex) begin
            o_plan.wr_en = has_room;
            o_f1_cnt     = fill_put;
            o_fill       = fill_put;
            if (!i_byte[7]) begin
                o_plan.wr_data = i_byte;
                pass           = 1'b0;
                if (CMP_W'(fill_put) >= CMP_W'(lim_eff)) begin
                    o_plan.f1_en   = 1'b1;
                    o_plan.f1_cont = 1'b1;
                    o_fill         = '0;
                end
            end else begin
                // status byte closes the sysex, stamped with an end marker
                o_plan.wr_data = mbsu_pkg::STATUS_EOX;
                o_plan.f1_en   = 1'b1;
                o_fill         = '0;
                o_state.mode   = mbsu_pkg::MODE_IDLE;
                if (i_byte == mbsu_pkg::STATUS_EOX) begin
                    pass = 1'b0;
                end
            end
        end

        if (pass) begin
            if (i_byte == mbsu_pkg::STATUS_SYSEX) begin
                o_state.start_time = i_time;
                o_state.mode       = mbsu_pkg::MODE_SYSEX;
                o_fill             = FW'(1);
                if (o_plan.f1_en) begin
                    // memory still holds the chunk being flushed
                    o_plan.f0_late = 1'b1;
                end else begin
                    o_plan.wr_en   = 1'b1;
                    o_plan.wr_data = mbsu_pkg::STATUS_SYSEX;
                    o_wr_addr      = '0;
                end
            end else if (i_byte[7]) begin
                o_state.short_buffer   = {16'h0000, i_byte};
                o_state.short_fill     = 2'd1;
                o_state.bytes_left     = mbsu_pkg::data_count(i_byte);
                o_state.start_time     = i_time;
                o_state.mode           = mbsu_pkg::MODE_SHORT;
                o_state.running_status =
                    (i_byte[7:4] != mbsu_pkg::SYS_NIBBLE) ? i_byte : 8'h00;
            end else begin
                if (o_state.mode != mbsu_pkg::MODE_SHORT) begin
                    if (i_state.running_status == 8'h00) begin
                        keep = 1'b0;
                    end else begin
                        o_state.short_buffer = {16'h0000, i_state.running_status};
                        o_state.short_fill   = 2'd1;
                        o_state.bytes_left   = mbsu_pkg::data_count(i_state.running_status);
                        o_state.start_time   = i_time;
                        o_state.mode         = mbsu_pkg::MODE_SHORT;
                    end
                end
                if (keep && o_state.short_fill != 2'd3 && o_state.bytes_left != 2'd0) begin
                    unique case (o_state.short_fill)
                        2'd1:    o_state.short_buffer[15:8]  = o_state.short_buffer[15:8] | i_byte;
                        2'd2:    o_state.short_buffer[23:16] = o_state.short_buffer[23:16] | i_byte;
                        default: o_state.short_buffer[7:0]   = o_state.short_buffer[7:0] | i_byte;
                    endcase
                    o_state.short_fill = o_state.short_fill + 2'd1;
                    o_state.bytes_left = o_state.bytes_left - 2'd1;
                end
            end
            if (o_state.mode == mbsu_pkg::MODE_SHORT && o_state.bytes_left == 2'd0) begin
                o_plan.short_emit = 1'b1;
                o_state.mode      = mbsu_pkg::MODE_IDLE;
            end
        end

        // end of buffer pushes out what sysex has gathered
        if (i_end && o_state.mode == mbsu_pkg::MODE_SYSEX && o_fill != '0) begin
            o_plan.f2_en = 1'b1;
            o_f2_cnt     = o_fill;
            o_fill       = '0;
        end
    end

endmodule

@@ hw/rtl/midi_byte_stream_unpacker_unit.sv @@
// midi byte stream unpacker top level: parser registers, chunk memory and result sequencer
// a word is taken only while the sequencer is idle; a short or realtime event then goes from its
// sequencer state into the output register once that register is free, and a flush reads each
// chunk byte from memory (ST_RD), then loads it into the output register (ST_WAIT); a sysex
// opening behind a flush passes through ST_F0 to write its start byte into the memory
// reset (synchronous, active low) clears parser and sequencer, limit to 32; memory not cleared
module midi_byte_stream_unpacker_unit #(
    parameter int CHUNK_DEPTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input words
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  mbsu_pkg::t_in_item            i_in_item,
    // result words
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output mbsu_pkg::t_out_item           o_out_item,
    // chunk limit register
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mbsu_pkg::LIMIT_W-1:0]  i_cfg_data
);

    localparam int FW = $clog2(CHUNK_DEPTH + 1);
    localparam int AW = $clog2(CHUNK_DEPTH);

    // sequencer: results go out in the order realtime, first flush, short, end flush
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_RT    = 6'b000010,
        ST_RD    = 6'b000100,
        ST_WAIT  = 6'b001000,
        ST_F0    = 6'b010000,
        ST_SHORT = 6'b100000
    } t_seq;

    function automatic t_seq pick(input mbsu_pkg::t_plan p);
        t_seq s;
        priority if (p.rt_emit) begin
            s = ST_RT;
        end else if (p.f1_en) begin
            s = ST_RD;
        end else if (p.f0_late) begin
            s = ST_F0;
        end else if (p.short_emit) begin
            s = ST_SHORT;
        end else if (p.f2_en) begin
            s = ST_RD;
        end else begin
            s = ST_IDLE;
        end
        return s;
    endfunction

    t_seq                           r_seq, n_seq;
    mbsu_pkg::t_parse_state         r_st;
    logic [FW-1:0]                  r_fill;
    mbsu_pkg::t_plan                r_plan, n_plan;
    logic [FW-1:0]                  r_idx, n_idx;
    logic [FW-1:0]                  r_f1_cnt, r_f2_cnt;
    logic [63:0]                    r_f1_time;
    logic [7:0]                     r_rt_byte;
    logic [63:0]                    r_rt_time;
    logic [31:0]                    r_group;
    logic [mbsu_pkg::LIMIT_W-1:0]   r_limit;
    logic                           r_out_valid, n_out_valid;
    mbsu_pkg::t_out_item            r_out, n_out;

    mbsu_pkg::t_parse_state         dec_st;
    logic [FW-1:0]                  dec_fill;
    mbsu_pkg::t_plan                dec_plan;
    logic [AW-1:0]                  dec_wr_addr;
    logic [FW-1:0]                  dec_f1_cnt;
    logic [FW-1:0]                  dec_f2_cnt;

    logic                           in_accept;
    logic                           slot_free;
    logic                           out_load;
    logic                           fl_first;
    logic [FW-1:0]                  fl_cnt;
    logic                           fl_cont;
    logic [63:0]                    fl_time;
    logic                           fl_final;
    logic                           mem_wr_en;
    logic [AW-1:0]                  mem_wr_addr;
    logic [7:0]                     mem_wr_data;
    logic                           mem_rd_en;
    logic [7:0]                     mem_rd_data;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_seq != ST_IDLE;
    assign o_cfg_ready = r_seq == ST_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // output register frees up when empty or being taken this cycle
    assign slot_free = !r_out_valid || !i_out_stall;

    // the first flush runs off the count and time captured at accept, the end flush
    // off the state left after the word
    assign fl_first = r_plan.f1_en;
    assign fl_cnt   = fl_first ? r_f1_cnt : r_f2_cnt;
    assign fl_cont  = fl_first ? r_plan.f1_cont : 1'b1;
    assign fl_time  = fl_first ? r_f1_time : r_st.start_time;
    assign fl_final = (r_idx + FW'(1)) == fl_cnt;

    mbsu_decode #(
        .CHUNK_DEPTH (CHUNK_DEPTH)
    ) u_decode (
        .i_byte    (i_in_item.midi_byte),
        .i_time    (i_in_item.arrival_time),
        .i_end     (i_in_item.buffer_end),
        .i_limit   (r_limit),
        .i_state   (r_st),
        .i_fill    (r_fill),
        .o_state   (dec_st),
        .o_fill    (dec_fill),
        .o_plan    (dec_plan),
        .o_wr_addr (dec_wr_addr),
        .o_f1_cnt  (dec_f1_cnt),
        .o_f2_cnt  (dec_f2_cnt)
    );

    // chunk store: one byte per entry, read back in order during a flush
    mbsu_ram #(
        .WIDTH (8),
        .DEPTH (CHUNK_DEPTH)
    ) u_chunk_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (mem_rd_data)
    );

    always_comb begin
        n_seq       = r_seq;
        n_plan      = r_plan;
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        out_load    = 1'b0;
        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = dec_wr_addr;
        mem_wr_data = dec_plan.wr_data;

        unique case (r_seq)
            ST_IDLE: begin
                if (in_accept) begin
                    // data byte, sysex start byte or end marker goes into the store while the word is taken
                    mem_wr_en = dec_plan.wr_en;
                    n_plan    = dec_plan;
                    n_seq     = pick(dec_plan);
                end
            end
            ST_RT: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    n_out    = '{
                        kind:            mbsu_pkg::KIND_SHORT,
                        short_bytes:     {16'h0000, r_rt_byte},
                        short_len:       2'd1,
                        sysex_byte:      8'h00,
                        chunk_end:       1'b0,
                        chunk_continued: 1'b0,
                        event_time:      r_rt_time,
                        event_group:     r_group,
                        last:            !(r_plan.f1_en || r_plan.short_emit || r_plan.f2_en)
                    };
                    n_plan.rt_emit = 1'b0;
                    n_seq          = pick(n_plan);
                end
            end
            ST_RD: begin
                mem_rd_en = 1'b1;
                n_seq     = ST_WAIT;
            end
            ST_WAIT: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    n_out    = '{
                        kind:            mbsu_pkg::KIND_SYSEX,
                        short_bytes:     24'h000000,
                        short_len:       2'd0,
                        sysex_byte:      mem_rd_data,
                        chunk_end:       fl_final,
                        chunk_continued: fl_cont,
                        event_time:      fl_time,
                        event_group:     r_group,
                        last:            fl_final && !(fl_first &&
                                         (r_plan.short_emit || r_plan.f2_en))
                    };
                    if (fl_final) begin
                        n_idx = '0;
                        if (fl_first) begin
                            n_plan.f1_en = 1'b0;
                        end else begin
                            n_plan.f2_en = 1'b0;
                        end
                        n_seq = pick(n_plan);
                    end else begin
                        n_idx = r_idx + FW'(1);
                        n_seq = ST_RD;
                    end
                end
            end
            ST_F0: begin
                // new sysex opens once the old chunk has been read out
                mem_wr_en      = 1'b1;
                mem_wr_addr    = '0;
                mem_wr_data    = mbsu_pkg::STATUS_SYSEX;
                n_plan.f0_late = 1'b0;
                n_seq          = pick(n_plan);
            end
            ST_SHORT: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    n_out    = '{
                        kind:            mbsu_pkg::KIND_SHORT,
                        short_bytes:     r_st.short_buffer,
                        short_len:       r_st.short_fill,
                        sysex_byte:      8'h00,
                        chunk_end:       1'b0,
                        chunk_continued: 1'b0,
                        event_time:      r_st.start_time,
                        event_group:     r_group,
                        last:            !r_plan.f2_en
                    };
                    n_plan.short_emit = 1'b0;
                    n_seq             = pick(n_plan);
                end
            end
            default: begin
                n_seq = ST_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= ST_IDLE;
            r_st        <= mbsu_pkg::PARSE_RESET;
            r_fill      <= '0;
            r_plan      <= '0;
            r_idx       <= '0;
            r_limit     <= mbsu_pkg::LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_plan      <= n_plan;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (in_accept) begin
                r_st   <= dec_st;
                r_fill <= dec_fill;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // payload captured per word and the output item, no reset needed
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (in_accept) begin
            r_f1_cnt  <= dec_f1_cnt;
            r_f2_cnt  <= dec_f2_cnt;
            r_f1_time <= r_st.start_time;
            r_rt_byte <= i_in_item.midi_byte;
            r_rt_time <= i_in_item.arrival_time;
            r_group   <= i_in_item.channel_group;
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(CHUNK_DEPTH))
        else $error("chunk fill beyond store depth");

    a_flush_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == ST_WAIT) |-> (r_idx < fl_cnt))
        else $error("flush read index past chunk length");

    a_last_ends_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && n_out.last) |=> (r_seq == ST_IDLE || r_seq == ST_F0))
        else $error("result marked last but more results pending");

    a_short_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == ST_IDLE && r_st.mode == mbsu_pkg::MODE_SHORT) |->
        (r_st.bytes_left != 2'd0 && r_st.short_fill != 2'd0))
        else $error("open short message with nothing left to collect");
`endif

endmodule
